// ----- rtl/core/fpsp_pkg.sv -----
// Shared constants, codes and control/status types for the span plotter.
`timescale 1ns / 1ps
`default_nettype none
package fpsp_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 128;

    localparam int CAM_W  = 16;
    localparam int CLIP_W = 14;
    localparam int COL_W  = 8;
    localparam int PAT_W  = 17;
    localparam int PAL_W  = 64;
    localparam int ADDR_W = 13;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;

    // clip edges are 7-bit; the right and bottom edges are further limited by the screen size
    localparam logic [6:0] CR_MAX = (SCREEN_WIDTH - 1 > 127) ? 7'd127 : 7'(SCREEN_WIDTH - 1);
    localparam logic [6:0] CB_MAX = (SCREEN_HEIGHT - 1 > 127) ? 7'd127 : 7'(SCREEN_HEIGHT - 1);
    localparam logic [ADDR_W-1:0] HALF_W = ADDR_W'(SCREEN_WIDTH / 2);

    localparam logic [CLIP_W-1:0] CLIP_RESET  = 14'h3F80;
    localparam logic [COL_W-1:0]  COLOR_RESET = 8'h06;
    localparam logic [PAL_W-1:0]  PAL_RESET   = 64'hFEDC_BA98_7654_3210;

    typedef enum logic [IDX_W-1:0] {
        CFG_CAMERA_X     = 3'd0,
        CFG_CAMERA_Y     = 3'd1,
        CFG_CLIP_X_RANGE = 3'd2,
        CFG_CLIP_Y_RANGE = 3'd3,
        CFG_DRAW_COLOR   = 3'd4,
        CFG_FILL_PATTERN = 3'd5,
        CFG_DRAW_PALETTE = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic load;
        logic sub;
        logic clip;
        logic step;
        logic flush;
    } fpsp_cmd_t;

    typedef struct packed {
        logic clip_empty;
        logic byte_nz;
        logic held_valid;
        logic at_end;
        logic out_free;
    } fpsp_status_t;

    function automatic logic [3:0] pal_lookup(input logic [PAL_W-1:0] pal,
                                              input logic [3:0] idx);
        pal_lookup = pal[{idx, 2'b00} +: 4];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fpsp_channels.sv -----
// Item channel interfaces: span request in, framebuffer byte write out.
`timescale 1ns / 1ps
`default_nettype none
interface fpsp_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [15:0] x_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_pos;

    modport source (output valid, cmd, x_start, x_end, y_pos, input ready);
    modport sink   (input valid, cmd, x_start, x_end, y_pos, output ready);
endinterface

interface fpsp_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] byte_addr;
    logic [7:0]  pixel_data;
    logic [1:0]  nibble_enable;
    logic        last;

    modport source (output valid, byte_addr, pixel_data, nibble_enable, last, input ready);
    modport sink   (input valid, byte_addr, pixel_data, nibble_enable, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/fill_pattern_span_plotter.sv -----
// Top level of the 4x4 fill-pattern span plotter for a 4bpp framebuffer.
//
// in_ch carries one item: a point (cmd 0) or a horizontal span (cmd 1) in
// canvas coordinates. The block subtracts the camera, clips, applies the
// fill pattern and palette, and sends framebuffer byte writes on out_ch in
// increasing address order, the final one of an item marked with last.
// cfg_we/cfg_index/cfg_data write the registers; write only while idle.
// An item is taken in the idle state, then passes through camera subtract and
// clipping; the scan then visits one byte per cycle unless the output register
// holds it (see below), and a flush state retires the final byte write.
// An item that clips away goes back to idle and gives no write.
// A byte write leaves after the next non-empty byte is found, the final one
// in the flush cycle. out_ch has an output register: the next write
// waits only while it is full and out_ch.ready is low; the scan then holds.
// A new item is taken as soon as the previous scan has flushed, even with a
// write still waiting in the output register.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the
// register defaults: no camera, full 0..127 clip, color 6, solid pattern,
// identity palette.
`timescale 1ns / 1ps
`default_nettype none
module fill_pattern_span_plotter
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    fpsp_in_if.sink                         in_ch,
    fpsp_out_if.source                      out_ch,
    input  wire logic                       cfg_we,
    input  wire logic [fpsp_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [fpsp_pkg::CFG_W-1:0] cfg_data
);
    import fpsp_pkg::*;

    fpsp_cmd_t    cmd;
    fpsp_status_t st;

    fpsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    fpsp_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_cmd     (in_ch.cmd),
        .in_x_start (in_ch.x_start),
        .in_x_end   (in_ch.x_end),
        .in_y_pos   (in_ch.y_pos),
        .cmd        (cmd),
        .st         (st),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_addr   (out_ch.byte_addr),
        .out_data   (out_ch.pixel_data),
        .out_en     (out_ch.nibble_enable),
        .out_last   (out_ch.last)
    );

endmodule
`default_nettype wire

// ----- rtl/core/fpsp_ctrl.sv -----
// Sequencer: item accept, camera subtract, clip, byte scan and final flush.
`timescale 1ns / 1ps
`default_nettype none
module fpsp_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire fpsp_pkg::fpsp_status_t st,
    output fpsp_pkg::fpsp_cmd_t        cmd
);
    import fpsp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SUB   = 5'b00010,
        S_CLIP  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   can_step;

    assign can_step = !(st.byte_nz && st.held_valid) || st.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SUB;
                end
            end
            S_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = S_CLIP;
            end
            S_CLIP:
            begin
                cmd.clip   = 1'b1;
                state_next = st.clip_empty ? S_IDLE : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.step = can_step;
                if (can_step && st.at_end)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!st.held_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/fpsp_datapath.sv -----
// Datapath: config registers, camera/clip arithmetic, byte builder, output register.
`timescale 1ns / 1ps
`default_nettype none
module fpsp_datapath
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [fpsp_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [fpsp_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                         in_cmd,
    input  wire logic signed [15:0]           in_x_start,
    input  wire logic signed [15:0]           in_x_end,
    input  wire logic signed [15:0]           in_y_pos,
    input  wire fpsp_pkg::fpsp_cmd_t          cmd,
    output fpsp_pkg::fpsp_status_t            st,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic [fpsp_pkg::ADDR_W-1:0]       out_addr,
    output logic [7:0]                        out_data,
    output logic [1:0]                        out_en,
    output logic                              out_last
);
    import fpsp_pkg::*;

    // configuration
    logic signed [CAM_W-1:0] cam_x_reg, cam_y_reg;
    logic [CLIP_W-1:0]       clip_x_reg, clip_y_reg;
    logic [COL_W-1:0]        color_reg;
    logic [PAT_W-1:0]        pat_reg;
    logic [PAL_W-1:0]        pal_reg;

    // item working registers
    logic signed [15:0] xa_reg, xb_reg, y_reg;
    logic signed [16:0] dxs_reg, dxe_reg, dy_reg;
    logic [6:0]         xs_reg, xe_reg, sy_reg;
    logic [5:0]         bcur_reg, bend_reg;
    logic [3:0]         row_reg, col0_reg, col1_reg;
    logic               transp_reg;

    // one pending byte, held until the next non-empty byte or the end is seen
    logic              held_valid_reg;
    logic [ADDR_W-1:0] held_addr_reg;
    logic [7:0]        held_data_reg;
    logic [1:0]        held_en_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [7:0]        out_data_reg;
    logic [1:0]        out_en_reg;
    logic              out_last_reg;

    // clip stage
    logic signed [16:0] cl_s, cr_s, ct_s, cb_s, xs_cl, xe_cl;
    logic [6:0]         cr_lim, cb_lim;
    logic               y_ok, nonempty;
    logic [1:0]         row_sel;

    // scan stage
    logic [6:0]        x0, x1;
    logic              in0, in1, bit0, bit1, en0, en1;
    logic [3:0]        nib0, nib1;
    logic [ADDR_W-1:0] addr_c;
    logic              push;

    assign cr_lim  = (clip_x_reg[13:7] > CR_MAX) ? CR_MAX : clip_x_reg[13:7];
    assign cb_lim  = (clip_y_reg[13:7] > CB_MAX) ? CB_MAX : clip_y_reg[13:7];
    assign cl_s    = $signed({10'b0, clip_x_reg[6:0]});
    assign cr_s    = $signed({10'b0, cr_lim});
    assign ct_s    = $signed({10'b0, clip_y_reg[6:0]});
    assign cb_s    = $signed({10'b0, cb_lim});
    assign xs_cl   = (dxs_reg < cl_s) ? cl_s : dxs_reg;
    assign xe_cl   = (dxe_reg > cr_s) ? cr_s : dxe_reg;
    assign y_ok    = (dy_reg >= ct_s) && (dy_reg <= cb_s);
    assign nonempty = y_ok && (xs_cl <= xe_cl);
    assign row_sel = ~dy_reg[1:0];

    // pattern column c sits at row bit 3-c
    assign x0   = {bcur_reg, 1'b0};
    assign x1   = {bcur_reg, 1'b1};
    assign in0  = (x0 >= xs_reg) && (x0 <= xe_reg);
    assign in1  = (x1 >= xs_reg) && (x1 <= xe_reg);
    assign bit0 = row_reg[{~bcur_reg[0], 1'b1}];
    assign bit1 = row_reg[{~bcur_reg[0], 1'b0}];
    assign en0  = in0 && !(transp_reg && bit0);
    assign en1  = in1 && !(transp_reg && bit1);
    assign nib0 = en0 ? (bit0 ? col1_reg : col0_reg) : 4'h0;
    assign nib1 = en1 ? (bit1 ? col1_reg : col0_reg) : 4'h0;
    assign addr_c = ({6'b0, sy_reg} * HALF_W) + {7'b0, bcur_reg};

    assign push = (cmd.step && (en0 || en1) && held_valid_reg) || cmd.flush;

    assign st.clip_empty = !nonempty;
    assign st.byte_nz    = en0 || en1;
    assign st.held_valid = held_valid_reg;
    assign st.at_end     = (bcur_reg == bend_reg);
    assign st.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_addr  = out_addr_reg;
    assign out_data  = out_data_reg;
    assign out_en    = out_en_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            clip_x_reg <= CLIP_RESET;
            clip_y_reg <= CLIP_RESET;
            color_reg  <= COLOR_RESET;
            pat_reg    <= '0;
            pal_reg    <= PAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAMERA_X:     cam_x_reg  <= $signed(cfg_data[CAM_W-1:0]);
                CFG_CAMERA_Y:     cam_y_reg  <= $signed(cfg_data[CAM_W-1:0]);
                CFG_CLIP_X_RANGE: clip_x_reg <= cfg_data[CLIP_W-1:0];
                CFG_CLIP_Y_RANGE: clip_y_reg <= cfg_data[CLIP_W-1:0];
                CFG_DRAW_COLOR:   color_reg  <= cfg_data[COL_W-1:0];
                CFG_FILL_PATTERN: pat_reg    <= cfg_data[PAT_W-1:0];
                CFG_DRAW_PALETTE: pal_reg    <= cfg_data[PAL_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            xa_reg <= in_x_start;
            xb_reg <= in_cmd ? in_x_end : in_x_start;
            y_reg  <= in_y_pos;
        end
        if (cmd.sub)
        begin
            dxs_reg <= 17'(xa_reg) - 17'(cam_x_reg);
            dxe_reg <= 17'(xb_reg) - 17'(cam_x_reg);
            dy_reg  <= 17'(y_reg) - 17'(cam_y_reg);
        end
        if (cmd.clip)
        begin
            xs_reg     <= xs_cl[6:0];
            xe_reg     <= xe_cl[6:0];
            bcur_reg   <= xs_cl[6:1];
            bend_reg   <= xe_cl[6:1];
            sy_reg     <= dy_reg[6:0];
            row_reg    <= pat_reg[{1'b0, row_sel, 2'b00} +: 4];
            transp_reg <= pat_reg[16];
            col0_reg   <= pal_lookup(pal_reg, color_reg[3:0]);
            col1_reg   <= pal_lookup(pal_reg, color_reg[7:4]);
        end
        else if (cmd.step)
        begin
            bcur_reg <= bcur_reg + 6'd1;
        end
        if (cmd.step && (en0 || en1))
        begin
            held_addr_reg <= addr_c;
            held_data_reg <= {nib1, nib0};
            held_en_reg   <= {en1, en0};
        end
        if (push)
        begin
            out_addr_reg <= held_addr_reg;
            out_data_reg <= held_data_reg;
            out_en_reg   <= held_en_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clip || cmd.flush)
            begin
                held_valid_reg <= 1'b0;
            end
            else if (cmd.step && (en0 || en1))
            begin
                held_valid_reg <= 1'b1;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ----- tb/sv/fpsp_write_checker.sv -----
// Checker for the span plotter: predicts the framebuffer byte writes and compares them.
`timescale 1ns / 1ps
module fpsp_write_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    fpsp_in_if                             in_ch,
    fpsp_out_if                            out_ch,
    input  logic                           cfg_we,
    input  logic [fpsp_pkg::IDX_W-1:0]     cfg_index,
    input  logic [fpsp_pkg::CFG_W-1:0]     cfg_data,
    output int                             mismatches,
    output int                             outstanding
);
    import fpsp_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic [1:0]        en;
        logic              last;
    } fb_write_t;

    fb_write_t expected_writes[$];

    logic signed [CAM_W-1:0] cam_x;
    logic signed [CAM_W-1:0] cam_y;
    logic [CLIP_W-1:0]       clip_x;
    logic [CLIP_W-1:0]       clip_y;
    logic [COL_W-1:0]        color;
    logic [PAT_W-1:0]        pattern;
    logic [PAL_W-1:0]        palette;

    function automatic logic [3:0] remap(input logic [PAL_W-1:0] pal, input logic [3:0] c);
        logic [PAL_W-1:0] shifted;
        shifted = pal >> (c * 4);
        return shifted[3:0];
    endfunction

    task automatic queue_write(input fb_write_t w);
        expected_writes.insert(expected_writes.size(), w);
    endtask

    // Byte writes of one point or span, queued in address order.
    task automatic plot_item(input logic cmd, input logic signed [15:0] xa,
                             input logic signed [15:0] xb, input logic signed [15:0] ya);
        int        sx;
        int        ex;
        int        sy;
        int        cl;
        int        cr;
        int        ct;
        int        cb;
        int        x;
        int        cur_byte;
        logic [3:0] row_bits;
        logic [3:0] shade;
        logic       pat_bit;
        fb_write_t  cur;
        fb_write_t  held;
        logic       have_held;
        sx = int'(xa) - int'(cam_x);
        ex = (cmd ? int'(xb) : int'(xa)) - int'(cam_x);
        sy = int'(ya) - int'(cam_y);
        cl = int'(clip_x[6:0]);
        cr = int'(clip_x[13:7]);
        ct = int'(clip_y[6:0]);
        cb = int'(clip_y[13:7]);
        if (cr > SCREEN_WIDTH - 1)
            cr = SCREEN_WIDTH - 1;
        if (cb > SCREEN_HEIGHT - 1)
            cb = SCREEN_HEIGHT - 1;
        if (sy < ct || sy > cb)
            return;
        if (sx < cl)
            sx = cl;
        if (ex > cr)
            ex = cr;
        if (sx > ex)
            return;
        row_bits  = pattern[15 - 4 * (sy % 4) -: 4];
        cur       = '0;
        held      = '0;
        have_held = 1'b0;
        cur_byte  = -1;
        // one pass beyond the end retires the final byte
        for (x = sx; x <= ex + 1; x++)
        begin
            pat_bit = row_bits[3 - (x % 4)];
            if (x > ex || (x / 2) != cur_byte)
            begin
                if (cur.en != 2'b00)
                begin
                    if (have_held)
                        queue_write(held);
                    held      = cur;
                    have_held = 1'b1;
                end
                cur_byte = x / 2;
                cur.addr = ADDR_W'(sy * (SCREEN_WIDTH / 2) + cur_byte);
                cur.data = '0;
                cur.en   = '0;
                cur.last = 1'b0;
            end
            if (x <= ex && !(pattern[16] && pat_bit))
            begin
                shade = remap(palette, pat_bit ? color[7:4] : color[3:0]);
                if (x % 2 == 1)
                begin
                    cur.data[7:4] = shade;
                    cur.en[1]     = 1'b1;
                end
                else
                begin
                    cur.data[3:0] = shade;
                    cur.en[0]     = 1'b1;
                end
            end
        end
        if (have_held)
        begin
            held.last = 1'b1;
            queue_write(held);
        end
    endtask

    task automatic flag(input string what, input fb_write_t want, input fb_write_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected %h %h %b %b, got %h %h %b %b",
                     $time, what, want.addr, want.data, want.en, want.last,
                     got.addr, got.data, got.en, got.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        fb_write_t got;
        fb_write_t want;
        if (!rst_n)
        begin
            cam_x       = '0;
            cam_y       = '0;
            clip_x      = CLIP_RESET;
            clip_y      = CLIP_RESET;
            color       = COLOR_RESET;
            pattern     = '0;
            palette     = PAL_RESET;
            mismatches  = 0;
            outstanding = 0;
            expected_writes.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CAMERA_X:     cam_x   = cfg_data[CAM_W-1:0];
                    CFG_CAMERA_Y:     cam_y   = cfg_data[CAM_W-1:0];
                    CFG_CLIP_X_RANGE: clip_x  = cfg_data[CLIP_W-1:0];
                    CFG_CLIP_Y_RANGE: clip_y  = cfg_data[CLIP_W-1:0];
                    CFG_DRAW_COLOR:   color   = cfg_data[COL_W-1:0];
                    CFG_FILL_PATTERN: pattern = cfg_data[PAT_W-1:0];
                    CFG_DRAW_PALETTE: palette = cfg_data[PAL_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                plot_item(in_ch.cmd, in_ch.x_start, in_ch.x_end, in_ch.y_pos);
            if (out_ch.valid && out_ch.ready)
            begin
                got.addr = out_ch.byte_addr;
                got.data = out_ch.pixel_data;
                got.en   = out_ch.nibble_enable;
                got.last = out_ch.last;
                if (expected_writes.size() == 0)
                    flag("write with none expected", '0, got);
                else
                begin
                    want = expected_writes.pop_front();
                    if (got.addr !== want.addr || got.data !== want.data ||
                        got.en !== want.en || got.last !== want.last)
                        flag("write mismatch", want, got);
                end
            end
            outstanding = expected_writes.size();
        end
    end

endmodule

// ----- tb/sv/fill_pattern_span_plotter_tb.sv -----
// Testbench top for the span plotter: reset, register setup, item stimulus and verdict.
`timescale 1ns / 1ps
module fill_pattern_span_plotter_tb;
    import fpsp_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               mismatches;
    int               outstanding;
    bit               idle_on = 1'b1;
    int               hold_requests = 0;
    int               hold_served = 0;
    logic signed [CAM_W-1:0] cam_x_now = '0;
    logic signed [CAM_W-1:0] cam_y_now = '0;

    fpsp_in_if  in_ch ();
    fpsp_out_if out_ch ();

    fill_pattern_span_plotter uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fpsp_write_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("fill_pattern_span_plotter test failed");
        $finish;
    end

    // Write side stalls: random bursts, plus a long hold on request.
    initial
    begin : sink_side
        int n;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_served != hold_requests)
            begin
                hold_served++;
                out_ch.ready <= 1'b0;
                n = 400;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 14);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                n = $urandom_range(1, 6);
            end
            repeat (n) @(negedge clk);
        end
    end

    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // Canvas coordinate that mostly lands near the visible area.
    function automatic logic signed [15:0] near(input logic signed [15:0] anchor);
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return sat16(int'(anchor) + int'($urandom_range(0, 167)) - 20);
    endfunction

    function automatic logic [CLIP_W-1:0] rand_clip();
        logic [6:0] lo;
        logic [6:0] hi;
        lo = 7'($urandom_range(0, 127));
        if ($urandom_range(0, 4) == 0)
            hi = 7'($urandom_range(0, 127));
        else
            hi = 7'($urandom_range(lo, 127));
        return {hi, lo};
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_all(input logic signed [15:0] cx, input logic signed [15:0] cy,
                           input logic [CLIP_W-1:0] clx, input logic [CLIP_W-1:0] cly,
                           input logic [COL_W-1:0] col, input logic [PAT_W-1:0] pat,
                           input logic [PAL_W-1:0] pal);
        write_reg(CFG_CAMERA_X, CFG_W'(cx));
        write_reg(CFG_CAMERA_Y, CFG_W'(cy));
        write_reg(CFG_CLIP_X_RANGE, CFG_W'(clx));
        write_reg(CFG_CLIP_Y_RANGE, CFG_W'(cly));
        write_reg(CFG_DRAW_COLOR, CFG_W'(col));
        write_reg(CFG_FILL_PATTERN, CFG_W'(pat));
        write_reg(CFG_DRAW_PALETTE, pal);
        cam_x_now = cx;
        cam_y_now = cy;
    endtask

    task automatic send_item(input logic cmd, input logic signed [15:0] xa,
                             input logic signed [15:0] xb, input logic signed [15:0] ya);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= cmd;
        in_ch.x_start <= xa;
        in_ch.x_end   <= xb;
        in_ch.y_pos   <= ya;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic random_item();
        logic              cmd;
        logic signed [15:0] xa;
        logic signed [15:0] xb;
        logic signed [15:0] ya;
        cmd = ($urandom_range(0, 9) < 7);
        xa  = near(cam_x_now);
        if ($urandom_range(0, 4) == 0)
            xb = near(cam_x_now);
        else
            xb = sat16(int'(xa) + int'($urandom_range(0, 150)) - 8);
        ya  = near(cam_y_now);
        send_item(cmd, xa, xb, ya);
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Items that clip away or draw nothing can still be in flight.
    task automatic settle();
        drain();
        repeat (80) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int p;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = 1'b0;
        in_ch.x_start = '0;
        in_ch.x_end   = '0;
        in_ch.y_pos   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values
        send_item(1'b0, 16'sd0, 16'sd0, 16'sd0);
        send_item(1'b0, 16'sd127, -16'sd1, 16'sd127);
        send_item(1'b0, -16'sd1, 16'sd5, 16'sd3);
        send_item(1'b0, 16'sd128, 16'sd128, 16'sd3);
        send_item(1'b0, 16'sd5, 16'sd5, 16'h8000);
        send_item(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(1'b1, 16'h8000, 16'h7FFF, 16'sd64);
        send_item(1'b1, 16'sd10, 16'sd5, 16'sd7);
        send_item(1'b1, 16'sd3, 16'sd4, 16'sd9);
        send_item(1'b1, 16'h8000, 16'h8000, 16'sd1);
        send_item(1'b1, 16'sd126, 16'sd127, 16'sd0);
        repeat (30) random_item();

        // camera at the extremes, narrow horizontal clip, mixed pattern
        settle();
        set_all(16'h8000, 16'h7FFF, {7'd100, 7'd10}, {7'd127, 7'd0}, 8'hA3, 17'h05A5A,
                64'h0123_4567_89AB_CDEF);
        hold_requests++;
        send_item(1'b1, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_item(1'b0, -16'sd32759, 16'sd0, 16'h7FFF);
        repeat (30) random_item();

        // inverted clip on both axes: nothing drawn
        settle();
        set_all(16'h7FFF, 16'h8000, {7'd20, 7'd50}, {7'd3, 7'd90}, 8'h5C, 17'h00F0F,
                64'h1111_2222_3333_4444);
        send_item(1'b1, 16'h8000, 16'h7FFF, -16'sd32700);
        repeat (8) random_item();

        // one-pixel clip window at the top right corner
        settle();
        set_all(16'sd0, 16'sd0, 14'h3FFF, 14'h0000, 8'hFF, 17'h0F00F, 64'h0);
        send_item(1'b1, 16'sd0, 16'sd200, 16'sd0);
        repeat (10) random_item();

        // transparent pattern
        settle();
        set_all(-16'sd3, 16'sd2, {7'd127, 7'd0}, {7'd127, 7'd0}, 8'h9C, 17'h1A5F0,
                {$urandom, $urandom});
        send_item(1'b1, -16'sd50, 16'sd200, 16'sd2);
        send_item(1'b1, -16'sd50, 16'sd200, 16'sd3);
        send_item(1'b1, -16'sd50, 16'sd200, 16'sd4);
        send_item(1'b1, -16'sd50, 16'sd200, 16'sd5);
        repeat (20) random_item();
        drain();
        repeat (20) random_item();

        // every pixel transparent
        settle();
        set_all(16'sd0, 16'sd0, {7'd127, 7'd0}, {7'd127, 7'd0}, 8'h31, 17'h1FFFF,
                {$urandom, $urandom});
        send_item(1'b1, 16'sd0, 16'sd127, 16'sd40);
        repeat (6) random_item();

        // solid high-nibble pattern through an all-ones palette
        settle();
        set_all(16'sd0, 16'sd0, {7'd127, 7'd0}, {7'd127, 7'd0}, 8'h50, 17'h0FFFF,
                64'hFFFF_FFFF_FFFF_FFFF);
        repeat (10) random_item();

        for (p = 0; p < 4; p++)
        begin
            settle();
            if (p == 3)
                idle_on = 1'b0;
            set_all(sat16(int'($urandom_range(0, 40)) - 20), sat16(int'($urandom_range(0, 40)) - 20),
                    rand_clip(), rand_clip(), 8'($urandom), 17'($urandom),
                    {$urandom, $urandom});
            repeat (20) random_item();
        end

        drain();
        repeat (80) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("fill_pattern_span_plotter test passed");
        else
            $display("fill_pattern_span_plotter test failed");
        $finish;
    end

endmodule
